### hdl/r2fft_pkg.sv
`timescale 1ns / 1ps
package r2fft_pkg;
    localparam int MAX_POINTS_DEF   = 64;
    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int TWIDDLE_BITS_DEF = 16;
    localparam int WORK_BITS        = 34;
    localparam int GRID             = 64;
    localparam int CFG_IDX_BITS     = 1;
    localparam logic CFG_INVERSE    = 1'b0;
    localparam logic CFG_LOG2       = 1'b1;

    // cos(2*pi*m/64) scaled by 2^31, m = 0..16
    function automatic logic [31:0] cos_q31(input logic [4:0] m);
        logic [31:0] r;
        begin
            case (m)
                5'd0:  r = 32'd2147483648;
                5'd1:  r = 32'd2137142927;
                5'd2:  r = 32'd2106220352;
                5'd3:  r = 32'd2055013723;
                5'd4:  r = 32'd1984016189;
                5'd5:  r = 32'd1893911494;
                5'd6:  r = 32'd1785567396;
                5'd7:  r = 32'd1660027308;
                5'd8:  r = 32'd1518500250;
                5'd9:  r = 32'd1362349204;
                5'd10: r = 32'd1193077991;
                5'd11: r = 32'd1012316784;
                5'd12: r = 32'd821806413;
                5'd13: r = 32'd623381598;
                5'd14: r = 32'd418953276;
                5'd15: r = 32'd210490206;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // Magnitude of a quarter-wave coefficient, rounded to the twiddle grid.
    function automatic logic [24:0] q_of(input logic [4:0] m, input int tb);
        logic [32:0] t;
        begin
            t = {1'b0, cos_q31(m)} + (33'd1 << (31 - tb));
            return 25'(t >> (32 - tb));
        end
    endfunction

    function automatic logic signed [25:0] tw_cos(input logic [5:0] m, input int tb);
        logic signed [25:0] r;
        begin
            if (m <= 6'd16)      r = $signed({1'b0, q_of(m[4:0], tb)});
            else if (m <= 6'd32) r = -$signed({1'b0, q_of(5'(6'd32 - m), tb)});
            else if (m <= 6'd48) r = -$signed({1'b0, q_of(5'(m - 6'd32), tb)});
            else                 r = $signed({1'b0, q_of(5'(7'd64 - {1'b0, m}), tb)});
            return r;
        end
    endfunction
endpackage

### hdl/r2fft_bfly.sv
`timescale 1ns / 1ps
// Shared butterfly: one complex multiply spread over registered stages.
module r2fft_bfly #(
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] ar,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] ai,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] br,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] bi,
    input  logic signed [25:0]                  wr,
    input  logic signed [25:0]                  wi,
    input  logic                                phase,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] xr,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] xi,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] yr,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] yi
);
    localparam int W = r2fft_pkg::WORK_BITS;
    localparam int P = W + 26;
    localparam logic signed [P-1:0] HALF = P'(1) <<< (TWIDDLE_BITS - 2);
    localparam logic signed [W+1:0] HI = (W+2)'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [W+1:0] LO = -HI - 1;

    logic signed [P-1:0] p1_reg, p2_reg, tr_reg;

    function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
        if (v > HI) return W'(HI);
        if (v < LO) return W'(LO);
        return W'(v);
    endfunction

    logic signed [P-1:0] tr_s, ti_s;
    logic signed [W+1:0] sar, sai, sbr, sbi;

    // Phase 0 forms br*wr and bi*wi, phase 1 forms br*wi and bi*wr.
    always_ff @(posedge aclk) begin
        if (!phase) begin
            p1_reg <= P'(br * wr);
            p2_reg <= P'(bi * wi);
        end else begin
            p1_reg <= P'(br * wi);
            p2_reg <= P'(bi * wr);
            tr_reg <= (p1_reg - p2_reg + HALF) >>> (TWIDDLE_BITS - 1);
        end
    end

    // In the write-back cycle the product registers hold br*wi and bi*wr.
    assign tr_s = tr_reg;
    assign ti_s = (p1_reg + p2_reg + HALF) >>> (TWIDDLE_BITS - 1);
    assign sar = (W+2)'(ar) + (W+2)'(tr_s);
    assign sai = (W+2)'(ai) + (W+2)'(ti_s);
    assign sbr = (W+2)'(ar) - (W+2)'(tr_s);
    assign sbi = (W+2)'(ai) - (W+2)'(ti_s);
    assign xr = sat(sar);
    assign xi = sat(sai);
    assign yr = sat(sbr);
    assign yi = sat(sbi);
endmodule

### hdl/radix2_fft_fwd_inv.sv
`timescale 1ns / 1ps
// Radix-2 decimation-in-time FFT, forward (real input) or inverse.
// Input channel s_*: one sample word per handshake; the word with
// s_sample_last set starts the transform. Samples beyond n are dropped and
// a short frame is padded with zeros. Config channel cfg_*: index 0 is
// inverse_mode, index 1 is log2_points; write only while idle.
// While loading, a sample is taken every cycle. After the last sample the
// block clears the padding, reorders the buffer into bit-reversed order,
// then runs n/2*log2(n) butterflies on one shared complex multiplier, each
// as memory read, two multiply phases and write back, then reads the n
// bins in natural order from memory into an output register, loading each
// bin once the register is empty or its bin is taken, m_bin_last on the final one.
// The input is not ready from the last sample until the last bin is
// loaded into the output register.
// A stalled receiver holds the bin register and pauses the read-out.
// Reset (aresetn low, synchronous) clears the configuration to forward
// mode at 64 points and empties the load count.
module radix2_fft_fwd_inv #(
    parameter int MAX_POINTS   = r2fft_pkg::MAX_POINTS_DEF,
    parameter int SAMPLE_BITS  = r2fft_pkg::SAMPLE_BITS_DEF,
    parameter int TWIDDLE_BITS = r2fft_pkg::TWIDDLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_im,
    input  logic                          s_sample_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [r2fft_pkg::CFG_IDX_BITS:0] cfg_index,
    input  logic [2:0]                    cfg_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_re,
    output logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_im,
    output logic                          m_bin_last
);
    localparam int W  = r2fft_pkg::WORK_BITS;
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int MAXLOG = AW;

    localparam logic [2:0] ST_LOAD = 3'd0, ST_PAD = 3'd1, ST_RD = 3'd2,
                           ST_M0 = 3'd3, ST_M1 = 3'd4, ST_WR = 3'd5,
                           ST_OUT = 3'd6, ST_BR = 3'd7;

    logic signed [W-1:0] mre [MAX_POINTS];
    logic signed [W-1:0] mim [MAX_POINTS];

    logic [2:0]  state_reg;
    logic        inv_reg;
    logic [2:0]  log2_reg;
    logic [AW:0] cnt_reg;
    logic [2:0]  lg_reg;
    logic        finv_reg;
    logic [2:0]  stg_reg;   // stage, 1..lg
    logic [AW-1:0] bf_reg;  // butterfly index in stage
    logic        brph_reg;  // bit reversal swap phase
    logic signed [W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [W-1:0] ov_re_reg, ov_im_reg;
    logic        ov_valid_reg, ov_last_reg;
    logic        rd_pend_reg;
    logic [AW:0] rd_idx_reg;

    logic [2:0]  lg_eff;
    logic [AW:0] n_eff, n_run;
    logic [AW-1:0] ia, ib, mask_h;
    logic [5:0]  tw_m;
    logic signed [25:0] wr, wi;
    logic signed [W-1:0] xr, xi, yr, yi;
    logic [AW-1:0] rev_i;

    always_comb begin
        lg_eff = log2_reg;
        if (lg_eff == 3'd0) lg_eff = 3'd1;
        if (lg_eff > 3'(MAXLOG)) lg_eff = 3'(MAXLOG);
    end
    assign n_eff = (AW+1)'(1) << lg_eff;
    assign n_run = (AW+1)'(1) << lg_reg;

    // Butterfly addresses: insert a zero at bit (stg-1) of bf, b sets it.
    always_comb begin
        mask_h = AW'((AW+1)'(1) << (stg_reg - 3'd1)) - AW'(1);
        ia = ((bf_reg & ~mask_h) << 1) | (bf_reg & mask_h);
        ib = ia | AW'((AW+1)'(1) << (stg_reg - 3'd1));
        tw_m = 6'((bf_reg & mask_h) << (3'd6 - stg_reg));
        wr = r2fft_pkg::tw_cos(tw_m, TWIDDLE_BITS);
        wi = finv_reg ? r2fft_pkg::tw_cos(6'(tw_m - 6'd16), TWIDDLE_BITS)
                      : -r2fft_pkg::tw_cos(6'(tw_m - 6'd16), TWIDDLE_BITS);
    end

    always_comb begin
        rev_i = '0;
        for (int k = 0; k < AW; k++)
            if (k < lg_reg) rev_i[lg_reg - 3'd1 - 3'(k)] = cnt_reg[k];
    end

    r2fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
        .aclk(aclk), .ar(ar_reg), .ai(ai_reg), .br(br_reg), .bi(bi_reg),
        .wr(wr), .wi(wi), .phase(state_reg == ST_M1),
        .xr(xr), .xi(xi), .yr(yr), .yi(yi)
    );

    assign s_ready   = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = ov_valid_reg;
    assign m_bin_re  = ov_re_reg;
    assign m_bin_im  = ov_im_reg;
    assign m_bin_last = ov_last_reg;

    logic ov_free;
    logic ov_load;
    assign ov_free = !ov_valid_reg || m_ready;
    assign ov_load = (state_reg == ST_OUT) && rd_pend_reg && ov_free;

    // Memory ports: the bit reversal swap and butterflies read two addresses per
    // array into operand registers in one state and write both back in a later state.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_LOAD: if (s_valid && cnt_reg < n_eff) begin
                mre[cnt_reg[AW-1:0]] <= W'(s_sample_re);
                mim[cnt_reg[AW-1:0]] <= inv_reg ? W'(s_sample_im) : '0;
            end
            ST_PAD: if (cnt_reg < n_run) begin
                mre[cnt_reg[AW-1:0]] <= '0;
                mim[cnt_reg[AW-1:0]] <= '0;
            end
            ST_BR: if (!brph_reg) begin
                ar_reg <= mre[cnt_reg[AW-1:0]];
                ai_reg <= mim[cnt_reg[AW-1:0]];
                br_reg <= mre[rev_i];
                bi_reg <= mim[rev_i];
            end else if (AW'(rev_i) > cnt_reg[AW-1:0]) begin
                mre[cnt_reg[AW-1:0]] <= br_reg;
                mim[cnt_reg[AW-1:0]] <= bi_reg;
                mre[rev_i] <= ar_reg;
                mim[rev_i] <= ai_reg;
            end
            ST_RD: begin
                ar_reg <= mre[ia];
                ai_reg <= mim[ia];
                br_reg <= mre[ib];
                bi_reg <= mim[ib];
            end
            ST_WR: begin
                mre[ia] <= xr;
                mim[ia] <= xi;
                mre[ib] <= yr;
                mim[ib] <= yi;
            end
            ST_OUT: if (!rd_pend_reg && rd_idx_reg < n_run) begin
                ar_reg <= mre[rd_idx_reg[AW-1:0]];
                ai_reg <= mim[rd_idx_reg[AW-1:0]];
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            inv_reg <= 1'b0;
            log2_reg <= 3'd6;
            cnt_reg <= '0;
            ov_valid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            brph_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == 2'(r2fft_pkg::CFG_INVERSE)) inv_reg <= cfg_data[0];
                else if (cfg_index == 2'(r2fft_pkg::CFG_LOG2)) log2_reg <= cfg_data;
            end
            if (ov_valid_reg && m_ready && !ov_load) ov_valid_reg <= 1'b0;
            case (state_reg)
                ST_LOAD: if (s_valid) begin
                    if (cnt_reg < n_eff) cnt_reg <= cnt_reg + 1'b1;
                    if (s_sample_last) begin
                        lg_reg <= lg_eff;
                        finv_reg <= inv_reg;
                        state_reg <= ST_PAD;
                    end
                end
                ST_PAD: if (cnt_reg < n_run) cnt_reg <= cnt_reg + 1'b1;
                    else begin
                        cnt_reg <= '0;
                        brph_reg <= 1'b0;
                        state_reg <= ST_BR;
                    end
                ST_BR: begin
                    brph_reg <= !brph_reg;
                    if (brph_reg) begin
                        if (cnt_reg == n_run - 1'b1) begin
                            stg_reg <= 3'd1;
                            bf_reg <= '0;
                            state_reg <= ST_RD;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_RD: state_reg <= ST_M0;
                ST_M0: state_reg <= ST_M1;
                ST_M1: state_reg <= ST_WR;
                ST_WR: begin
                    state_reg <= ST_RD;
                    if ((AW+1)'(bf_reg) == (n_run >> 1) - 1'b1) begin
                        bf_reg <= '0;
                        if (stg_reg == lg_reg) begin
                            state_reg <= ST_OUT;
                            rd_idx_reg <= '0;
                            rd_pend_reg <= 1'b0;
                        end else stg_reg <= stg_reg + 3'd1;
                    end else bf_reg <= bf_reg + 1'b1;
                end
                ST_OUT: begin
                    if (!rd_pend_reg && rd_idx_reg < n_run) begin
                        rd_pend_reg <= 1'b1;
                    end else if (rd_pend_reg && ov_free) begin
                        rd_pend_reg <= 1'b0;
                        ov_valid_reg <= 1'b1;
                        ov_re_reg <= finv_reg ? (ar_reg >>> lg_reg) : ar_reg;
                        ov_im_reg <= finv_reg ? '0 : ai_reg;
                        ov_last_reg <= (rd_idx_reg == n_run - 1'b1);
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        if (rd_idx_reg == n_run - 1'b1) begin
                            cnt_reg <= '0;
                            state_reg <= ST_LOAD;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule

### bench/fft_checker.sv
`timescale 1ns / 1ps
module fft_checker (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    input  logic                                   s_ready,
    input  logic signed [23:0]                     s_sample_re,
    input  logic signed [23:0]                     s_sample_im,
    input  logic                                   s_sample_last,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic [r2fft_pkg::CFG_IDX_BITS:0]       cfg_index,
    input  logic [2:0]                             cfg_data,
    input  logic                                   m_valid,
    input  logic                                   m_ready,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_re,
    input  logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_im,
    input  logic                                   m_bin_last,
    output int                                     fail_count,
    output int                                     bins_pending
);
    localparam int TW = r2fft_pkg::TWIDDLE_BITS_DEF;
    localparam int WB = r2fft_pkg::WORK_BITS;
    localparam int GP = r2fft_pkg::GRID;
    localparam logic [r2fft_pkg::CFG_IDX_BITS:0] REG_INVERSE =
        (r2fft_pkg::CFG_IDX_BITS + 1)'(r2fft_pkg::CFG_INVERSE);
    localparam logic [r2fft_pkg::CFG_IDX_BITS:0] REG_LOG2 =
        (r2fft_pkg::CFG_IDX_BITS + 1)'(r2fft_pkg::CFG_LOG2);

    typedef struct packed {
        logic signed [WB-1:0] re;
        logic signed [WB-1:0] im;
        logic                 last;
    } bin_t;

    // Quarter-wave cosine table, 2*pi*m/64 scaled by 2^31.
    localparam logic [31:0] COS_TAB [17] = '{
        32'd2147483648, 32'd2137142927, 32'd2106220352, 32'd2055013723,
        32'd1984016189, 32'd1893911494, 32'd1785567396, 32'd1660027308,
        32'd1518500250, 32'd1362349204, 32'd1193077991, 32'd1012316784,
        32'd821806413,  32'd623381598,  32'd418953276,  32'd210490206, 32'd0};

    longint   buf_re [GP];
    longint   buf_im [GP];
    int       fill_level;
    logic     mode_inv;
    logic [2:0] len_reg;
    bin_t     bin_q [$];

    function automatic longint quarter_coef(int m);
        longint t;
        t = longint'(COS_TAB[m]) + (longint'(1) << (31 - TW));
        return t >> (32 - TW);
    endfunction

    function automatic longint cos_coef(int m);
        m = m & 63;
        if (m <= 16) return quarter_coef(m);
        if (m <= 32) return -quarter_coef(32 - m);
        if (m <= 48) return -quarter_coef(m - 32);
        return quarter_coef(64 - m);
    endfunction

    function automatic longint clip_work(longint v);
        longint hi;
        hi = (longint'(1) << (WB - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic int points_log2();
        if (len_reg < 1) return 1;
        if (len_reg > 6) return 6;
        return int'(len_reg);
    endfunction

    task automatic transform_frame(int lg);
        int n, j, half_len, stride, a, b, m;
        longint wr, wi, tr, ti, ar, ai, br, bi, t;
        n = 1 << lg;
        for (int i = 0; i < n; i++) begin
            j = 0;
            for (int k = 0; k < lg; k++) j |= ((i >> k) & 1) << (lg - 1 - k);
            if (j > i) begin
                t = buf_re[i]; buf_re[i] = buf_re[j]; buf_re[j] = t;
                t = buf_im[i]; buf_im[i] = buf_im[j]; buf_im[j] = t;
            end
        end
        for (int len = 2; len <= n; len <<= 1) begin
            half_len = len >> 1;
            stride = GP / len;
            for (int base = 0; base < n; base += len) begin
                for (int k = 0; k < half_len; k++) begin
                    a = base + k;
                    b = a + half_len;
                    m = k * stride;
                    wr = cos_coef(m);
                    wi = mode_inv ? cos_coef((m - 16) & 63) : -cos_coef((m - 16) & 63);
                    br = buf_re[b];
                    bi = buf_im[b];
                    tr = (br * wr - bi * wi + (longint'(1) << (TW - 2))) >>> (TW - 1);
                    ti = (br * wi + bi * wr + (longint'(1) << (TW - 2))) >>> (TW - 1);
                    ar = buf_re[a];
                    ai = buf_im[a];
                    buf_re[a] = clip_work(ar + tr);
                    buf_im[a] = clip_work(ai + ti);
                    buf_re[b] = clip_work(ar - tr);
                    buf_im[b] = clip_work(ai - ti);
                end
            end
        end
    endtask

    task automatic take_sample(longint re, longint im, logic last);
        int lg, n;
        bin_t e;
        lg = points_log2();
        n = 1 << lg;
        if (fill_level < n) begin
            buf_re[fill_level] = re;
            buf_im[fill_level] = mode_inv ? im : 0;
            fill_level++;
        end
        if (last) begin
            for (int i = fill_level; i < n; i++) begin
                buf_re[i] = 0;
                buf_im[i] = 0;
            end
            fill_level = 0;
            transform_frame(lg);
            for (int i = 0; i < n; i++) begin
                e.re = mode_inv ? WB'(buf_re[i] >>> lg) : WB'(buf_re[i]);
                e.im = mode_inv ? '0 : WB'(buf_im[i]);
                e.last = (i == n - 1);
                bin_q.push_back(e);
            end
        end
    endtask

    task automatic report_mismatch(string what);
        $display("%0t: bin mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign bins_pending = bin_q.size();

    always @(posedge aclk) begin
        bin_t e;
        if (!aresetn) begin
            fill_level = 0;
            mode_inv = 1'b0;
            len_reg = 3'd6;
            bin_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_INVERSE) mode_inv = cfg_data[0];
                else if (cfg_index == REG_LOG2) len_reg = cfg_data;
            end
            if (s_valid && s_ready)
                take_sample(longint'(s_sample_re), longint'(s_sample_im), s_sample_last);
            if (m_valid && m_ready) begin
                if (bin_q.size() == 0) begin
                    report_mismatch("word with nothing expected");
                end else begin
                    e = bin_q.pop_front();
                    if (m_bin_re !== e.re)
                        report_mismatch($sformatf("re got %0d want %0d", m_bin_re, e.re));
                    if (m_bin_im !== e.im)
                        report_mismatch($sformatf("im got %0d want %0d", m_bin_im, e.im));
                    if (m_bin_last !== e.last)
                        report_mismatch($sformatf("last got %0b want %0b", m_bin_last, e.last));
                end
            end
        end
    end
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    localparam int IB = r2fft_pkg::CFG_IDX_BITS;
    localparam logic [IB:0] REG_INVERSE  = (IB + 1)'(r2fft_pkg::CFG_INVERSE);
    localparam logic [IB:0] REG_LOG2     = (IB + 1)'(r2fft_pkg::CFG_LOG2);
    localparam logic [IB:0] REG_SPARE_LO = 2'd2;
    localparam logic [IB:0] REG_SPARE_HI = 2'd3;
    localparam logic signed [23:0] S_MAX = 24'sd8388607;
    localparam logic signed [23:0] S_MIN = -24'sd8388608;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [23:0] s_sample_re = '0;
    logic signed [23:0] s_sample_im = '0;
    logic s_sample_last = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IB:0] cfg_index = '0;
    logic [2:0] cfg_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_re;
    logic signed [r2fft_pkg::WORK_BITS-1:0] m_bin_im;
    logic m_bin_last;
    int fail_count;
    int bins_pending;

    bit calm = 1'b0;       // no idling on either side
    bit hold_off = 1'b0;   // receiver stalls for a long stretch
    logic [2:0] cur_log2 = 3'd6;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    radix2_fft_fwd_inv u_dut (.*);

    fft_checker u_check (.*);

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                hold_off = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            m_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    task automatic send_sample(logic signed [23:0] re, logic signed [23:0] im, logic last);
        while (!calm && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample_re <= re;
        s_sample_im <= im;
        s_sample_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [IB:0] idx, logic [2:0] data);
        s_valid <= 1'b0;
        while (bins_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        if (idx == REG_LOG2) cur_log2 = data;
    endtask

    function automatic int frame_points();
        if (cur_log2 < 1) return 2;
        if (cur_log2 > 6) return 64;
        return 1 << cur_log2;
    endfunction

    task automatic send_frame(int count);
        for (int i = 0; i < count; i++)
            send_sample(24'($urandom), 24'($urandom), i == count - 1);
    endtask

    initial begin
        int n, sent, kind, count;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: extremes in both modes, padding, dropped samples, clamped lengths.
        write_reg(REG_LOG2, 3'd1);
        send_sample(S_MAX, S_MAX, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b1);
        write_reg(REG_INVERSE, 3'd1);
        send_sample(S_MIN, S_MIN, 1'b0);
        send_sample(S_MAX, S_MAX, 1'b1);
        send_sample(-24'sd1, 24'sd0, 1'b0);
        send_sample(24'sd0, -24'sd1, 1'b0);
        send_sample(S_MAX, S_MIN, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b1);
        write_reg(REG_SPARE_LO, 3'd0);
        write_reg(REG_SPARE_HI, 3'd7);
        write_reg(REG_LOG2, 3'd2);
        send_sample(S_MIN, S_MIN, 1'b1);
        write_reg(REG_LOG2, 3'd0);
        send_sample(-24'sd3, 24'sd5, 1'b0);
        send_sample(24'sd7, -24'sd1, 1'b1);
        write_reg(REG_INVERSE, 3'd0);
        write_reg(REG_LOG2, 3'd7);
        send_sample(S_MAX, S_MIN, 1'b0);
        send_sample(S_MIN, S_MAX, 1'b1);

        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_INVERSE, 3'($urandom));
            if (ph == 3) write_reg(REG_LOG2, 3'd6);
            else if (ph == 7) write_reg(REG_LOG2, $urandom_range(1) ? 3'd7 : 3'd0);
            else write_reg(REG_LOG2, 3'($urandom_range(1, 4)));
            calm = (ph == 2);
            if (ph == 5) hold_off = 1'b1;
            n = frame_points();
            sent = 0;
            while (sent < 22) begin
                kind = $urandom_range(99);
                if (kind < 75) count = n;
                else if (kind < 87) count = $urandom_range(1, n);
                else count = n + $urandom_range(1, 3);
                send_frame(count);
                sent += count;
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        while (bins_pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS radix2_fft_fwd_inv");
        else
            $display("FAIL radix2_fft_fwd_inv");
        $finish;
    end

    initial begin
        #10ms;
        $display("FAIL radix2_fft_fwd_inv");
        $finish;
    end
endmodule

### filelist.f
hdl/r2fft_pkg.sv
hdl/r2fft_bfly.sv
hdl/radix2_fft_fwd_inv.sv
bench/fft_checker.sv
bench/tb_top.sv
